// ===== rtl/kfms_pkg.sv =====
// ----------------------------------------------------------------------------
// kfms_pkg
// Types and constants shared by the keyed frame marker search block.
// ----------------------------------------------------------------------------
package kfms_pkg;

    localparam int KEY_W      = 8;
    localparam int FRAME_W    = 16;
    localparam int SLOT_W     = 6;
    localparam int ECOUNT_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [SLOT_W-1:0]  entry_index;
        logic [KEY_W-1:0]   marker_key;
        logic [FRAME_W-1:0] entry_frame;
        logic [FRAME_W-1:0] source_frame;
        logic               allow_wrap;
    } kfms_in_t;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] result_frame;
    } kfms_out_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [FRAME_W-1:0] frame;
    } kfms_entry_t;

    typedef struct packed {
        logic load;
        logic query_start;
        logic issue;
        logic eval;
        logic finish;
    } kfms_cmd_t;

    typedef struct packed {
        logic no_search;
        logic hit;
        logic all_issued;
    } kfms_status_t;

endpackage

// ===== rtl/kfms_ram.sv =====
// ----------------------------------------------------------------------------
// kfms_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kfms_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/kfms_ctrl.sv =====
// ----------------------------------------------------------------------------
// kfms_ctrl
// Controller: sequences loads, query setup, the table walk and the result.
// ----------------------------------------------------------------------------
module kfms_ctrl
    import kfms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         mode,
    input  kfms_status_t status,
    output kfms_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_QUERY)
                    begin
                        cmd.query_start = 1'b1;
                        state_next      = ST_CHECK;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.no_search)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.eval = 1'b1;
                if (status.hit || status.all_issued)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/kfms_dp.sv =====
// ----------------------------------------------------------------------------
// kfms_dp
// Datapath: config registers, marker table, walk counter, fallback tracker
// and result register.
// ----------------------------------------------------------------------------
module kfms_dp
    import kfms_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  kfms_in_t              item,
    input  kfms_cmd_t             cmd,
    output kfms_status_t          status,
    output kfms_out_t             result,
    output logic                  strobe
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [FRAME_W-1:0]  frame_count_reg;
    logic [ECOUNT_W-1:0] entry_count_reg;

    logic [KEY_W-1:0]    key_reg;
    logic [FRAME_W-1:0]  src_reg;
    logic                wrap_reg;
    logic [CNT_W-1:0]    limit_reg;
    logic [CNT_W-1:0]    limit_next;
    logic                no_search_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                back_valid_reg;
    logic                back_valid_next;
    logic [FRAME_W-1:0]  back_frame_reg;
    logic [FRAME_W-1:0]  back_frame_next;
    kfms_out_t           result_reg;
    kfms_out_t           result_next;
    logic                strobe_reg;

    logic                wr_en;
    kfms_entry_t         wr_entry;
    kfms_entry_t         rd_entry;
    logic                match;
    logic                hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_COUNT: frame_count_reg <= cfg_data[FRAME_W-1:0];
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[ECOUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // table write, slots past the table are dropped
    assign wr_en          = cmd.load && (32'(item.entry_index) < 32'(MAX_ENTRIES));
    assign wr_entry.key   = item.marker_key;
    assign wr_entry.frame = item.entry_frame;

    kfms_ram #(
        .WIDTH ($bits(kfms_entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (IDX_W'(item.entry_index)),
        .wdata (wr_entry),
        .re    (cmd.issue),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    assign limit_next = (32'(entry_count_reg) > 32'(MAX_ENTRIES)) ?
                        CNT_W'(MAX_ENTRIES) : CNT_W'(entry_count_reg);

    assign match = (rd_entry.key == key_reg);
    assign hit   = match && (rd_entry.frame >= src_reg);

    always_comb
    begin
        back_valid_next = back_valid_reg;
        back_frame_next = back_frame_reg;
        if (match && (!back_valid_reg || (rd_entry.frame < back_frame_reg)))
        begin
            back_valid_next = 1'b1;
            back_frame_next = rd_entry.frame;
        end
    end

    always_comb
    begin
        result_next = '0;
        priority if (no_search_reg)
        begin
            result_next = '0;
        end
        else if (hit)
        begin
            result_next.found        = 1'b1;
            result_next.result_frame = rd_entry.frame;
        end
        else if (wrap_reg && back_valid_next)
        begin
            result_next.found        = 1'b1;
            result_next.result_frame = back_frame_next;
        end
        else
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            key_reg   <= item.marker_key;
            src_reg   <= item.source_frame;
            wrap_reg  <= item.allow_wrap;
            limit_reg <= limit_next;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_search_reg  <= 1'b0;
            idx_reg        <= '0;
            back_valid_reg <= 1'b0;
            back_frame_reg <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.finish;
            if (cmd.query_start)
            begin
                no_search_reg  <= (item.source_frame >= frame_count_reg) ||
                                  (limit_next == '0);
                idx_reg        <= '0;
                back_valid_reg <= 1'b0;
                back_frame_reg <= '0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (cmd.eval)
                begin
                    back_valid_reg <= back_valid_next;
                    back_frame_reg <= back_frame_next;
                end
            end
        end
    end

    assign status.no_search  = no_search_reg;
    assign status.hit        = hit;
    assign status.all_issued = (idx_reg == limit_reg);

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

// ===== rtl/keyed_frame_marker_search.sv =====
// ----------------------------------------------------------------------------
// keyed_frame_marker_search
// Marker table of (key, frame) entries with a forward search by key.
// ----------------------------------------------------------------------------
// Usage:
//   A beat is taken on a rising edge with start high and busy low.
//   item.mode = load writes item.marker_key / item.entry_frame into slot
//   item.entry_index; busy stays low and no result follows.
//   item.mode = query searches the first entry_count slots, at most
//   MAX_ENTRIES, for item.marker_key at or after item.source_frame, with
//   optional wrap to the smallest matching frame.
//   A query answers with one result beat: strobe is high for one cycle with
//   result valid. The controller takes a query through a check state and
//   then a scan state that reads the slots in turn; a query with the
//   source frame at or past frame_count, or with entry_count zero, reads
//   no slots and reports a miss. The walk reads one table slot per cycle
//   from the RAM read port.
//   Config writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
//   must make them only while the block is idle: the block does not enforce it.
//   Reset clears both config registers and the controller; table contents
//   stay undefined until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module keyed_frame_marker_search
    import kfms_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  kfms_in_t              item,
    output logic                  strobe,
    output kfms_out_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    kfms_cmd_t    cmd;
    kfms_status_t status;

    kfms_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (item.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    kfms_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .strobe    (strobe)
    );

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result beat while busy");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.found) |-> (result.result_frame == '0))
        else $error("miss result with nonzero frame");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.mode == MODE_QUERY)) |=> busy)
        else $error("query not started");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.mode == MODE_LOAD)) |=> (!busy && !strobe))
        else $error("load caused busy or result");

endmodule
